>>> design/rlbs_pkg.sv
// ----------------------------------------------------------------------------
// rlbs_pkg: shared types and constants of the RGB LED breathing sequencer
// Field widths, command and register codes, config and state records, and
// the countdown load helper.
// ----------------------------------------------------------------------------
package rlbs_pkg;

  localparam int DELAY_BITS = 16;  // countdown width, 4 to 32
  localparam int COLOR_W    = 24;
  localparam int LEVEL_W    = 8;
  localparam int STEP_W     = 8;
  localparam int DLY_W      = 16;
  localparam int STOP_W     = 2;
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_COLOR  = 3'd0,
    REG_MAX_COLOR  = 3'd1,
    REG_STEP_UP    = 3'd2,
    REG_STEP_DOWN  = 3'd3,
    REG_DELAY_UP   = 3'd4,
    REG_DELAY_DOWN = 3'd5,
    REG_STOP_FLAGS = 3'd6,
    REG_FIRST_DOWN = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0] min_color;
    logic [COLOR_W-1:0] max_color;
    logic [STEP_W-1:0]  rise_step;
    logic [STEP_W-1:0]  fall_step;
    logic [DLY_W-1:0]   rise_wait;
    logic [DLY_W-1:0]   fall_wait;
    logic [STOP_W-1:0]  stop_flags;
    logic               start_fall;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]    red;
    logic [LEVEL_W-1:0]    green;
    logic [LEVEL_W-1:0]    blue;
    logic                  dir_down;
    logic                  run;
    logic                  armed;
    logic [DELAY_BITS-1:0] ticks;
  } state_t;

  localparam logic [63:0]           TICK_MAX = (64'd1 << DELAY_BITS) - 64'd1;
  localparam logic [DELAY_BITS-1:0] TICK_ONE = DELAY_BITS'(1);

  // Saturate a delay setting into the countdown width.
  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [DLY_W-1:0] d);
    if (64'(d) > TICK_MAX) begin
      return TICK_MAX[DELAY_BITS-1:0];
    end
    return DELAY_BITS'(d);
  endfunction

endpackage

>>> design/rlbs_cfg.sv
// ----------------------------------------------------------------------------
// rlbs_cfg: configuration register file
// Holds the eight settings; exposes both the held values and the values
// after the write in flight.
// ----------------------------------------------------------------------------
module rlbs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rlbs_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rlbs_pkg::COLOR_W-1:0]      cfg_wdata,
  output rlbs_pkg::cfg_t                    cfg_o,
  output rlbs_pkg::cfg_t                    cfg_nxt_o
);

  rlbs_pkg::cfg_t cfg_r;
  rlbs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rlbs_pkg::REG_MIN_COLOR:  cfg_nxt.min_color  = cfg_wdata;
        rlbs_pkg::REG_MAX_COLOR:  cfg_nxt.max_color  = cfg_wdata;
        rlbs_pkg::REG_STEP_UP:    cfg_nxt.rise_step  = cfg_wdata[rlbs_pkg::STEP_W-1:0];
        rlbs_pkg::REG_STEP_DOWN:  cfg_nxt.fall_step  = cfg_wdata[rlbs_pkg::STEP_W-1:0];
        rlbs_pkg::REG_DELAY_UP:   cfg_nxt.rise_wait  = cfg_wdata[rlbs_pkg::DLY_W-1:0];
        rlbs_pkg::REG_DELAY_DOWN: cfg_nxt.fall_wait  = cfg_wdata[rlbs_pkg::DLY_W-1:0];
        rlbs_pkg::REG_STOP_FLAGS: cfg_nxt.stop_flags = cfg_wdata[rlbs_pkg::STOP_W-1:0];
        rlbs_pkg::REG_FIRST_DOWN: cfg_nxt.start_fall = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_color  <= '0;
      cfg_r.max_color  <= '1;
      cfg_r.rise_step  <= rlbs_pkg::STEP_W'(5);
      cfg_r.fall_step  <= rlbs_pkg::STEP_W'(5);
      cfg_r.rise_wait  <= rlbs_pkg::DLY_W'(3);
      cfg_r.fall_wait  <= rlbs_pkg::DLY_W'(3);
      cfg_r.stop_flags <= '0;
      cfg_r.start_fall <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o     = cfg_r;
  assign cfg_nxt_o = cfg_nxt;

endmodule

>>> design/rlbs_step.sv
// ----------------------------------------------------------------------------
// rlbs_step: next-state logic for one command
// Tick countdown, fade step with clamping, start and stop.
// ----------------------------------------------------------------------------
module rlbs_step (
  input  rlbs_pkg::state_t                  state_i,
  input  rlbs_pkg::cfg_t                    cfg_i,
  input  logic [rlbs_pkg::FUNC_W-1:0]       func_i,
  input  logic [rlbs_pkg::COLOR_W-1:0]      color_i,
  output rlbs_pkg::state_t                  state_o,
  output logic                              stepped_o
);

  // Falling channel: lower only if not below the other two, clamp at lo.
  function automatic logic [7:0] fall_one(input logic [7:0] v, input logic [7:0] o1,
                                          input logic [7:0] o2, input logic [7:0] lo,
                                          input logic [7:0] s);
    logic signed [9:0] x;
    if (v == lo) begin
      return v;
    end
    if (v >= o1 && v >= o2) begin
      x = $signed({2'b00, v}) - $signed({2'b00, s});
    end else begin
      x = $signed({2'b00, v});
    end
    if (x <= $signed({2'b00, lo})) begin
      return lo;
    end
    return x[7:0];
  endfunction

  // Rising channel: add and clamp at hi.
  function automatic logic [7:0] rise_one(input logic [7:0] v, input logic [7:0] hi,
                                          input logic [7:0] s);
    logic [8:0] x;
    if (v == hi) begin
      return v;
    end
    x = {1'b0, v} + {1'b0, s};
    if (x >= {1'b0, hi}) begin
      return hi;
    end
    return x[7:0];
  endfunction

  logic [7:0] lo_r, lo_g, lo_b, hi_r, hi_g, hi_b;
  logic [7:0] dn_r, dn_g, dn_b, up_r, up_g, up_b;
  logic       at_min, at_max, halt;
  logic [rlbs_pkg::DLY_W-1:0] dly;

  assign lo_r = cfg_i.min_color[23:16];
  assign lo_g = cfg_i.min_color[15:8];
  assign lo_b = cfg_i.min_color[7:0];
  assign hi_r = cfg_i.max_color[23:16];
  assign hi_g = cfg_i.max_color[15:8];
  assign hi_b = cfg_i.max_color[7:0];

  // Falling channels chain on the already updated values.
  assign dn_r = fall_one(state_i.red,   state_i.green, state_i.blue, lo_r, cfg_i.fall_step);
  assign dn_g = fall_one(state_i.green, dn_r,          state_i.blue, lo_g, cfg_i.fall_step);
  assign dn_b = fall_one(state_i.blue,  dn_r,          dn_g,         lo_b, cfg_i.fall_step);
  assign up_r = rise_one(state_i.red,   hi_r, cfg_i.rise_step);
  assign up_g = rise_one(state_i.green, hi_g, cfg_i.rise_step);
  assign up_b = rise_one(state_i.blue,  hi_b, cfg_i.rise_step);

  assign at_min = (dn_r == lo_r) && (dn_g == lo_g) && (dn_b == lo_b);
  assign at_max = (up_r == hi_r) && (up_g == hi_g) && (up_b == hi_b);

  always_comb begin
    state_o   = state_i;
    stepped_o = 1'b0;
    halt      = 1'b0;
    dly       = state_i.dir_down ? cfg_i.fall_wait : cfg_i.rise_wait;
    case (func_i)
      rlbs_pkg::FUNC_TICK: begin
        if (state_i.armed) begin
          if (state_i.ticks > rlbs_pkg::TICK_ONE) begin
            state_o.ticks = state_i.ticks - rlbs_pkg::TICK_ONE;
          end else begin
            state_o.ticks = '0;
            state_o.armed = 1'b0;
            if (state_i.run) begin
              stepped_o = 1'b1;
              if (state_i.dir_down) begin
                state_o.red   = dn_r;
                state_o.green = dn_g;
                state_o.blue  = dn_b;
                if (at_min) begin
                  state_o.dir_down = 1'b0;
                  halt             = cfg_i.stop_flags[0];
                end
              end else begin
                state_o.red   = up_r;
                state_o.green = up_g;
                state_o.blue  = up_b;
                if (at_max) begin
                  state_o.dir_down = 1'b1;
                  halt             = cfg_i.stop_flags[1];
                end
              end
              if (!halt && dly != '0) begin
                state_o.armed = 1'b1;
                state_o.ticks = rlbs_pkg::sat_delay(dly);
              end
            end
          end
        end
      end
      rlbs_pkg::FUNC_START: begin
        state_o.run   = 1'b1;
        state_o.red   = color_i[23:16];
        state_o.green = color_i[15:8];
        state_o.blue  = color_i[7:0];
        state_o.armed = 1'b1;
        state_o.ticks = rlbs_pkg::sat_delay(dly);
      end
      rlbs_pkg::FUNC_STOP: begin
        state_o.run   = 1'b0;
        state_o.armed = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

>>> design/rgb_led_breathing_sequencer.sv
// ----------------------------------------------------------------------------
// rgb_led_breathing_sequencer: breathing fade engine for one RGB LED
//
// Usage:
// - Input channel (in_valid/in_ready): one command per transfer. in_func
//   selects tick, start (loads in_present_color) or stop.
// - Result channel (out_valid/out_ready): exactly one result per command,
//   carrying the color now driven, direction, run and countdown flags and
//   whether this command performed a brightness step.
// - Config port: cfg_we writes register cfg_index with cfg_wdata; the user
//   writes only while no command is in flight, not enforced by the block. A
//   write while running reloads the countdown for the current direction.
// Timing: a command is registered in the input register, then its result
//   in the result register; one command per cycle is sustained while
//   out_ready stays high, set by the single state update stage.
// Reset (rst_n low, synchronous): levels zero, falling direction, stopped,
//   countdown disarmed, settings at their defaults, both channels empty.
// Stall: while out_ready is low the result holds; the input register still
//   takes one more command, then in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module rgb_led_breathing_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rlbs_pkg::FUNC_W-1:0]       in_func,
  input  logic [rlbs_pkg::COLOR_W-1:0]      in_present_color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rlbs_pkg::COLOR_W-1:0]      out_color,
  output logic                              out_falling,
  output logic                              out_running,
  output logic                              out_armed,
  output logic                              out_stepped,
  input  logic                              cfg_we,
  input  logic [rlbs_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rlbs_pkg::COLOR_W-1:0]      cfg_wdata
);

  // Input register
  logic                          in_vld_r;
  logic [rlbs_pkg::FUNC_W-1:0]   in_func_r;
  logic [rlbs_pkg::COLOR_W-1:0]  in_color_r;

  // Engine state and result register
  rlbs_pkg::state_t              st_r, st_nxt, st_step;
  logic                          stepped;
  logic                          out_vld_r;
  rlbs_pkg::state_t              res_r;
  logic                          stepped_r;

  rlbs_pkg::cfg_t                cfg, cfg_nxt;
  logic                          fire;
  logic                          dir_new;

  // Advance a command when the result register is free or being drained.
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_func_r  <= in_func;
      in_color_r <= in_present_color;
    end
  end

  rlbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg),
    .cfg_nxt_o (cfg_nxt)
  );

  rlbs_step u_step (
    .state_i   (st_r),
    .cfg_i     (cfg),
    .func_i    (in_func_r),
    .color_i   (in_color_r),
    .state_o   (st_step),
    .stepped_o (stepped)
  );

  // Config write: the start direction register also sets direction; rearm
  // while running using the settings as they stand after this write.
  always_comb begin
    st_nxt  = st_r;
    dir_new = (cfg_index == rlbs_pkg::REG_FIRST_DOWN) ? cfg_wdata[0] : st_r.dir_down;
    if (cfg_we) begin
      st_nxt.dir_down = dir_new;
      if (st_r.run) begin
        st_nxt.armed = 1'b1;
        st_nxt.ticks = rlbs_pkg::sat_delay(dir_new ? cfg_nxt.fall_wait : cfg_nxt.rise_wait);
      end
    end else if (fire) begin
      st_nxt = st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{dir_down: 1'b1, default: '0};
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on fire, drop once the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r     <= st_step;
      stepped_r <= stepped;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_color   = {res_r.red, res_r.green, res_r.blue};
  assign out_falling = res_r.dir_down;
  assign out_running = res_r.run;
  assign out_armed   = res_r.armed;
  assign out_stepped = stepped_r;

endmodule

>>> design/rlbs_checker.sv
// ----------------------------------------------------------------------------
// rlbs_checker: port-level checks of the breathing sequencer
// Result channel holding and flag consistency, attached by bind.
// ----------------------------------------------------------------------------
module rlbs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rlbs_pkg::COLOR_W-1:0]      out_color,
  input logic                              out_running,
  input logic                              out_armed,
  input logic                              out_stepped
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color))
    else $error("result changed while stalled");

  // A step only happens while running.
  a_step_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stepped |-> out_running)
    else $error("step reported while stopped");

  // The countdown is only armed while running.
  a_armed_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_armed |-> out_running)
    else $error("countdown armed while stopped");

  // Reset empties both sides: no result, input open.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind rgb_led_breathing_sequencer rlbs_checker u_rlbs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_color   (out_color),
  .out_running (out_running),
  .out_armed   (out_armed),
  .out_stepped (out_stepped)
);

>>> tb/rgb_led_breathing_sequencer_tb.sv
// ----------------------------------------------------------------------------
// rgb_led_breathing_sequencer_tb: self-checking bench for the breathing engine
// Drives tick, start, stop and unused commands in random bursts and checks
// every result against an in-bench model of the fade engine. Register
// settings change between phases while the block is idle. The result
// channel stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module rgb_led_breathing_sequencer_tb;

  // The fourth selector value is not a command; the block only reports state.
  localparam logic [rlbs_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_CMDS    = 135;

  typedef struct packed {
    logic [rlbs_pkg::FUNC_W-1:0]  code;
    logic [rlbs_pkg::COLOR_W-1:0] color;
  } led_cmd_t;

  typedef struct packed {
    logic [rlbs_pkg::COLOR_W-1:0] color;
    logic                         falling;
    logic                         running;
    logic                         armed;
    logic                         stepped;
  } led_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [rlbs_pkg::FUNC_W-1:0] in_func = rlbs_pkg::FUNC_TICK;
  logic [rlbs_pkg::COLOR_W-1:0] in_present_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rlbs_pkg::COLOR_W-1:0] out_color;
  logic out_falling;
  logic out_running;
  logic out_armed;
  logic out_stepped;
  logic cfg_we = 1'b0;
  logic [rlbs_pkg::IDX_W-1:0] cfg_index = rlbs_pkg::REG_MIN_COLOR;
  logic [rlbs_pkg::COLOR_W-1:0] cfg_wdata = '0;

  rgb_led_breathing_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_present_color (in_present_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_color        (out_color),
    .out_falling      (out_falling),
    .out_running      (out_running),
    .out_armed        (out_armed),
    .out_stepped      (out_stepped),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Commands waiting for the driver, and results owed by the block.
  led_cmd_t    pending_cmds[$];
  led_result_t expected_leds[$];

  // Fade engine model: settings and live state.
  logic [rlbs_pkg::COLOR_W-1:0] set_min, set_max;
  logic [rlbs_pkg::STEP_W-1:0]  set_rise_step, set_fall_step;
  logic [rlbs_pkg::DLY_W-1:0]   set_dly_up, set_dly_down;
  logic [rlbs_pkg::STOP_W-1:0]  set_stop;
  logic                         set_start_fall;
  logic [rlbs_pkg::LEVEL_W-1:0] lvl_r, lvl_g, lvl_b;
  logic                         dir_down, run_on, cnt_armed;
  logic [31:0]                  ticks_left;

  int err_count = 0;
  int results_checked = 0;
  int cmds_taken = 0;
  int starts_taken = 0;
  int stops_taken = 0;
  int steps_seen = 0;
  int reversals = 0;
  int settings_used = 0;
  bit in_taken = 1'b0;

  // Load the countdown, saturating at the counter width.
  function automatic void arm_countdown(logic [rlbs_pkg::DLY_W-1:0] d);
    longint cap;
    cap = (longint'(1) << rlbs_pkg::DELAY_BITS) - 1;
    ticks_left = (longint'(d) > cap) ? 32'(cap) : 32'(d);
    cnt_armed = 1'b1;
  endfunction

  // Lower a channel only if it is not below the other two; clamp at its minimum.
  function automatic logic [rlbs_pkg::LEVEL_W-1:0] fade_down_chan(
      logic [rlbs_pkg::LEVEL_W-1:0] v, logic [rlbs_pkg::LEVEL_W-1:0] o1,
      logic [rlbs_pkg::LEVEL_W-1:0] o2, logic [rlbs_pkg::LEVEL_W-1:0] lo);
    int x;
    x = int'(v);
    if (v != lo) begin
      if (v >= o1 && v >= o2) x -= int'(set_fall_step);
      if (x <= int'(lo)) x = int'(lo);
    end
    return x[rlbs_pkg::LEVEL_W-1:0];
  endfunction

  function automatic logic [rlbs_pkg::LEVEL_W-1:0] fade_up_chan(
      logic [rlbs_pkg::LEVEL_W-1:0] v, logic [rlbs_pkg::LEVEL_W-1:0] hi);
    int x;
    x = int'(v);
    if (v != hi) begin
      x += int'(set_rise_step);
      if (x >= int'(hi)) x = int'(hi);
    end
    return x[rlbs_pkg::LEVEL_W-1:0];
  endfunction

  // Advance the model by one command and return the result it owes.
  function automatic led_result_t breathe_predict(logic [rlbs_pkg::FUNC_W-1:0] code,
      logic [rlbs_pkg::COLOR_W-1:0] pc);
    led_result_t r;
    logic [rlbs_pkg::DLY_W-1:0] next_dly;
    bit halt;
    bit did_step;
    did_step = 1'b0;
    halt = 1'b0;
    case (code)
      rlbs_pkg::FUNC_TICK: begin
        if (cnt_armed) begin
          if (ticks_left > 1) begin
            ticks_left--;
          end else begin
            ticks_left = 0;
            cnt_armed = 1'b0;
            if (run_on) begin
              did_step = 1'b1;
              if (dir_down) begin
                // Each channel sees the already lowered values of earlier ones.
                lvl_r = fade_down_chan(lvl_r, lvl_g, lvl_b, set_min[23:16]);
                lvl_g = fade_down_chan(lvl_g, lvl_r, lvl_b, set_min[15:8]);
                lvl_b = fade_down_chan(lvl_b, lvl_r, lvl_g, set_min[7:0]);
                next_dly = set_dly_down;
                if ({lvl_r, lvl_g, lvl_b} == set_min) begin
                  dir_down = 1'b0;
                  reversals++;
                  halt = set_stop[0];
                end
              end else begin
                lvl_r = fade_up_chan(lvl_r, set_max[23:16]);
                lvl_g = fade_up_chan(lvl_g, set_max[15:8]);
                lvl_b = fade_up_chan(lvl_b, set_max[7:0]);
                next_dly = set_dly_up;
                if ({lvl_r, lvl_g, lvl_b} == set_max) begin
                  dir_down = 1'b1;
                  reversals++;
                  halt = set_stop[1];
                end
              end
              if (halt || next_dly == 0) cnt_armed = 1'b0;
              else arm_countdown(next_dly);
            end
          end
        end
      end
      rlbs_pkg::FUNC_START: begin
        run_on = 1'b1;
        {lvl_r, lvl_g, lvl_b} = pc;
        arm_countdown(dir_down ? set_dly_down : set_dly_up);
      end
      rlbs_pkg::FUNC_STOP: begin
        run_on = 1'b0;
        cnt_armed = 1'b0;
      end
      default: ;
    endcase
    r.color   = {lvl_r, lvl_g, lvl_b};
    r.falling = dir_down;
    r.running = run_on;
    r.armed   = cnt_armed;
    r.stepped = did_step;
    return r;
  endfunction

  // Sender: hold each command until its transfer, then move on in bursts.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    led_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the command until it transfers
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      cmd = pending_cmds.pop_front();
      in_valid <= 1'b1;
      in_func <= cmd.code;
      in_present_color <= cmd.color;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(40, 1);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: switch between always ready, coin flips and long stalls.
  int rx_mode = 0;
  int rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(2);
      rx_left = $urandom_range(64, 8);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      default: out_ready <= ($urandom_range(7) == 0);
    endcase
  end

  // Monitor: check result transfers, then predict for command transfers.
  always @(posedge clk) begin : monitor
    led_result_t want, got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_color, out_falling, out_running, out_armed, out_stepped};
        if (expected_leds.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: result with nothing expected: color=%06h flags=%b%b%b%b",
                     got.color, got.falling, got.running, got.armed, got.stepped);
        end else begin
          want = expected_leds.pop_front();
          results_checked++;
          if (want.stepped) steps_seen++;
          if (got.color !== want.color || got.falling !== want.falling ||
              got.running !== want.running || got.armed !== want.armed ||
              got.stepped !== want.stepped) begin
            err_count++;
            if (err_count <= 10)
              $display({"ERROR: result %0d: color %06h/%06h falling %b/%b ",
                        "running %b/%b armed %b/%b stepped %b/%b (expected/actual)"},
                       results_checked, want.color, got.color, want.falling,
                       got.falling, want.running, got.running, want.armed,
                       got.armed, want.stepped, got.stepped);
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        cmds_taken++;
        if (in_func == rlbs_pkg::FUNC_START) starts_taken++;
        if (in_func == rlbs_pkg::FUNC_STOP) stops_taken++;
        expected_leds.push_back(breathe_predict(in_func, in_present_color));
      end
    end
  end

  task automatic push_cmd(logic [rlbs_pkg::FUNC_W-1:0] code,
                          logic [rlbs_pkg::COLOR_W-1:0] color);
    pending_cmds.push_back('{code: code, color: color});
  endtask

  // Random traffic: mostly ticks so the countdown runs out, with restarts.
  task automatic push_random(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 74) push_cmd(rlbs_pkg::FUNC_TICK, 24'($urandom));
      else if (pick < 87) push_cmd(rlbs_pkg::FUNC_START, 24'($urandom));
      else if (pick < 93) push_cmd(rlbs_pkg::FUNC_STOP, 24'($urandom));
      else push_cmd(FUNC_UNUSED, 24'($urandom));
    end
  endtask

  // Wait until every command has transferred and every result has come back.
  task automatic drain;
    while (pending_cmds.size() != 0 || in_valid || expected_leds.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register at a rising edge and mirror it in the model.
  task automatic write_setting(rlbs_pkg::reg_idx_t idx, logic [rlbs_pkg::COLOR_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      rlbs_pkg::REG_MIN_COLOR:  set_min = v;
      rlbs_pkg::REG_MAX_COLOR:  set_max = v;
      rlbs_pkg::REG_STEP_UP:    set_rise_step = v[rlbs_pkg::STEP_W-1:0];
      rlbs_pkg::REG_STEP_DOWN:  set_fall_step = v[rlbs_pkg::STEP_W-1:0];
      rlbs_pkg::REG_DELAY_UP:   set_dly_up = v[rlbs_pkg::DLY_W-1:0];
      rlbs_pkg::REG_DELAY_DOWN: set_dly_down = v[rlbs_pkg::DLY_W-1:0];
      rlbs_pkg::REG_STOP_FLAGS: set_stop = v[rlbs_pkg::STOP_W-1:0];
      rlbs_pkg::REG_FIRST_DOWN: begin
        set_start_fall = v[0];
        dir_down = v[0];
      end
      default: ;
    endcase
    // Any write while running reloads the countdown for the current direction.
    if (run_on) arm_countdown(dir_down ? set_dly_down : set_dly_up);
  endtask

  // Write all eight registers in a shuffled order, then drop the enable.
  task automatic program_settings(logic [rlbs_pkg::COLOR_W-1:0] vals [8]);
    int order [8];
    int j, t;
    for (int i = 0; i < 8; i++) order[i] = i;
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 8; i++)
      write_setting(rlbs_pkg::reg_idx_t'(order[i]), vals[order[i]]);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [rlbs_pkg::COLOR_W-1:0] vals [8];
    // Model matches the block's reset state.
    set_min = '0;
    set_max = 24'hffffff;
    set_rise_step = 8'd5;
    set_fall_step = 8'd5;
    set_dly_up = 16'd3;
    set_dly_down = 16'd3;
    set_stop = '0;
    set_start_fall = 1'b1;
    {lvl_r, lvl_g, lvl_b} = '0;
    dir_down = 1'b1;
    run_on = 1'b0;
    cnt_armed = 1'b0;
    ticks_left = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: idle tick, unused selector, full white fade,
    // a single leading channel, stop, and a start already on the minimum that
    // turns the fade around.
    settings_used++;
    push_cmd(rlbs_pkg::FUNC_TICK, 24'h000000);
    push_cmd(FUNC_UNUSED, 24'hffffff);
    push_cmd(rlbs_pkg::FUNC_START, 24'hffffff);
    repeat (3) push_cmd(rlbs_pkg::FUNC_TICK, 24'h000000);
    push_cmd(rlbs_pkg::FUNC_START, 24'h80ff00);
    repeat (3) push_cmd(rlbs_pkg::FUNC_TICK, 24'hffffff);
    push_cmd(rlbs_pkg::FUNC_STOP, 24'h000000);
    push_cmd(rlbs_pkg::FUNC_TICK, 24'h000000);
    push_cmd(rlbs_pkg::FUNC_START, 24'h000000);
    repeat (6) push_cmd(rlbs_pkg::FUNC_TICK, 24'h5a5a5a);
    drain();

    // Directed, tight window: start below the minimum and above the maximum,
    // both stop flags set so each reversal halts the countdown.
    vals[rlbs_pkg::REG_MIN_COLOR]  = 24'h404040;
    vals[rlbs_pkg::REG_MAX_COLOR]  = 24'hc0c0c0;
    vals[rlbs_pkg::REG_STEP_UP]    = 24'h80;
    vals[rlbs_pkg::REG_STEP_DOWN]  = 24'h80;
    vals[rlbs_pkg::REG_DELAY_UP]   = 24'd1;
    vals[rlbs_pkg::REG_DELAY_DOWN] = 24'd1;
    vals[rlbs_pkg::REG_STOP_FLAGS] = 24'd3;
    vals[rlbs_pkg::REG_FIRST_DOWN] = 24'd1;
    program_settings(vals);
    push_cmd(rlbs_pkg::FUNC_START, 24'h102030);
    push_cmd(rlbs_pkg::FUNC_TICK, 24'h000000);
    push_cmd(rlbs_pkg::FUNC_TICK, 24'h000000);
    push_cmd(rlbs_pkg::FUNC_START, 24'hf0f0f0);
    push_cmd(rlbs_pkg::FUNC_TICK, 24'h000000);
    push_cmd(rlbs_pkg::FUNC_TICK, 24'h000000);
    drain();

    // Extremes: full range, largest steps, zero delays stop after each step.
    vals[rlbs_pkg::REG_MIN_COLOR]  = 24'h000000;
    vals[rlbs_pkg::REG_MAX_COLOR]  = 24'hffffff;
    vals[rlbs_pkg::REG_STEP_UP]    = 24'hff;
    vals[rlbs_pkg::REG_STEP_DOWN]  = 24'hff;
    vals[rlbs_pkg::REG_DELAY_UP]   = 24'd0;
    vals[rlbs_pkg::REG_DELAY_DOWN] = 24'd0;
    vals[rlbs_pkg::REG_STOP_FLAGS] = 24'd0;
    vals[rlbs_pkg::REG_FIRST_DOWN] = 24'd1;
    program_settings(vals);
    push_random(150);
    drain();

    // Opposite extremes: inverted limits, zero steps, longest delays.
    vals[rlbs_pkg::REG_MIN_COLOR]  = 24'hffffff;
    vals[rlbs_pkg::REG_MAX_COLOR]  = 24'h000000;
    vals[rlbs_pkg::REG_STEP_UP]    = 24'h00;
    vals[rlbs_pkg::REG_STEP_DOWN]  = 24'h00;
    vals[rlbs_pkg::REG_DELAY_UP]   = 24'hffff;
    vals[rlbs_pkg::REG_DELAY_DOWN] = 24'hffff;
    vals[rlbs_pkg::REG_STOP_FLAGS] = 24'd3;
    vals[rlbs_pkg::REG_FIRST_DOWN] = 24'd0;
    program_settings(vals);
    push_random(40);
    drain();

    // Random settings; every fourth phase uses unconstrained limits.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 4 == 3) begin
        vals[rlbs_pkg::REG_MIN_COLOR] = 24'($urandom);
        vals[rlbs_pkg::REG_MAX_COLOR] = 24'($urandom);
      end else begin
        vals[rlbs_pkg::REG_MIN_COLOR] = {8'($urandom_range(80)), 8'($urandom_range(80)),
                                         8'($urandom_range(80))};
        vals[rlbs_pkg::REG_MAX_COLOR] = {8'($urandom_range(255, 170)),
                                         8'($urandom_range(255, 170)),
                                         8'($urandom_range(255, 170))};
      end
      vals[rlbs_pkg::REG_STEP_UP]    = 24'($urandom_range(96, 8));
      vals[rlbs_pkg::REG_STEP_DOWN]  = 24'($urandom_range(96, 8));
      vals[rlbs_pkg::REG_DELAY_UP]   = 24'($urandom_range(4));
      vals[rlbs_pkg::REG_DELAY_DOWN] = 24'($urandom_range(4));
      vals[rlbs_pkg::REG_STOP_FLAGS] = 24'($urandom_range(3));
      vals[rlbs_pkg::REG_FIRST_DOWN] = 24'($urandom_range(1));
      program_settings(vals);
      push_random(PHASE_CMDS);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d commands (%0d starts, %0d stops) over %0d register settings.",
             cmds_taken, starts_taken, stops_taken, settings_used);
    $display("Checked %0d results with %0d fade steps and %0d direction reversals.",
             results_checked, steps_seen, reversals);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("Timeout with %0d commands queued and %0d results outstanding",
             pending_cmds.size(), expected_leds.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
